@@ rtl/lwpw_pkg.sv @@
// shared types and constants for the lcd window pixel writer
// no dependencies

package lwpw_pkg;

    typedef enum logic [1:0] {
        FUNC_PIXEL  = 2'd0,
        FUNC_WINDOW = 2'd1,
        FUNC_PUSH   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_COLUMN_CMD = 2'd0,
        CFG_PAGE_CMD   = 2'd1,
        CFG_MEMWR_CMD  = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STEP_W  = 4;

    // byte positions within a full draw-pixel sequence
    localparam logic [STEP_W-1:0] STEP_COL_CMD  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_X_HI     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_X_LO     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_XE_HI    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_XE_LO    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_PAGE_CMD = 4'd5;
    localparam logic [STEP_W-1:0] STEP_Y_HI     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_Y_LO     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_YE_HI    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_YE_LO    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_MEMWR    = 4'd10;
    localparam logic [STEP_W-1:0] STEP_C_HI     = 4'd11;
    localparam logic [STEP_W-1:0] STEP_C_LO     = 4'd12;

    typedef struct packed {
        func_t              func;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ye;
        logic [COORD_W-1:0] color;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] column_cmd;
        logic [BYTE_W-1:0] page_cmd;
        logic [BYTE_W-1:0] memwr_cmd;
    } cmd_set_t;

endpackage

@@ rtl/lwpw_req_stage.sv @@
// input register: captures one request and works out the window end coordinates
// depends on lwpw_pkg

module lwpw_req_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [79:0]                s_axis_tdata,  // x_start, y_start, width, height, color
    input  logic [1:0]                 s_axis_tuser,  // func
    output logic                       req_valid,
    output lwpw_pkg::req_t             req,
    input  logic                       req_take
);
    import lwpw_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    req_t               req_reg;
    req_t               req_next;
    logic               load;
    func_t              func_in;
    logic [COORD_W-1:0] x_in;
    logic [COORD_W-1:0] y_in;
    logic [COORD_W-1:0] w_in;
    logic [COORD_W-1:0] h_in;

    assign func_in = func_t'(s_axis_tuser);
    assign x_in    = s_axis_tdata[15:0];
    assign y_in    = s_axis_tdata[31:16];
    assign w_in    = s_axis_tdata[47:32];
    assign h_in    = s_axis_tdata[63:48];

    assign s_axis_tready = !valid_reg || req_take;
    assign load          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        req_next       = req_reg;
        req_next.func  = func_in;
        req_next.x     = x_in;
        req_next.y     = y_in;
        req_next.color = s_axis_tdata[79:64];
        if (func_in == FUNC_PIXEL)
        begin
            req_next.xe = x_in;
            req_next.ye = y_in;
        end
        else
        begin
            req_next.xe = x_in + w_in - 16'd1;
            req_next.ye = y_in + h_in - 16'd1;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            // an unused selector is taken and dropped
            valid_next = (func_in != FUNC_NONE);
        end
        else if (req_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req_next;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

    a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |-> valid_reg)
        else $error("request released while none held");

    a_none_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (load && func_in == FUNC_NONE) |=> !valid_reg)
        else $error("unused selector held as a request");

    a_held_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !req_take) |=> (valid_reg && $stable(req_reg)))
        else $error("request changed while its bytes were still going out");

endmodule

@@ rtl/lwpw_byte_gen.sv @@
// byte sequencer and output register: one byte of the held request per beat
// depends on lwpw_pkg

module lwpw_byte_gen (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  lwpw_pkg::req_t             req,
    output logic                       req_take,
    input  lwpw_pkg::cmd_set_t         cmds,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // out_byte
    output logic                       m_axis_tuser,  // is_data
    output logic                       m_axis_tlast
);
    import lwpw_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              data_reg;
    logic              last_reg;
    logic              advance;
    logic              fire;
    logic [STEP_W-1:0] idx;
    logic [STEP_W-1:0] last_idx;
    logic [BYTE_W-1:0] sel_byte;
    logic              sel_data;

    assign advance  = !out_valid_reg || m_axis_tready;
    assign fire     = advance && req_valid;
    // push colour starts at the colour bytes
    assign idx      = step_reg + ((req.func == FUNC_PUSH) ? STEP_C_HI : STEP_COL_CMD);
    assign last_idx = (req.func == FUNC_WINDOW) ? STEP_MEMWR : STEP_C_LO;
    assign req_take = fire && (idx == last_idx);

    always_comb
    begin
        sel_data = 1'b1;
        unique case (idx)
            STEP_COL_CMD:
            begin
                sel_byte = cmds.column_cmd;
                sel_data = 1'b0;
            end
            STEP_X_HI:  sel_byte = req.x[15:8];
            STEP_X_LO:  sel_byte = req.x[7:0];
            STEP_XE_HI: sel_byte = req.xe[15:8];
            STEP_XE_LO: sel_byte = req.xe[7:0];
            STEP_PAGE_CMD:
            begin
                sel_byte = cmds.page_cmd;
                sel_data = 1'b0;
            end
            STEP_Y_HI:  sel_byte = req.y[15:8];
            STEP_Y_LO:  sel_byte = req.y[7:0];
            STEP_YE_HI: sel_byte = req.ye[15:8];
            STEP_YE_LO: sel_byte = req.ye[7:0];
            STEP_MEMWR:
            begin
                sel_byte = cmds.memwr_cmd;
                sel_data = 1'b0;
            end
            STEP_C_HI:  sel_byte = req.color[15:8];
            STEP_C_LO:  sel_byte = req.color[7:0];
            default:    sel_byte = '0;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = req_valid;
        end
        if (fire)
        begin
            step_next = req_take ? '0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg <= sel_byte;
            data_reg <= sel_data;
            last_reg <= req_take;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = byte_reg;
    assign m_axis_tuser  = data_reg;
    assign m_axis_tlast  = last_reg;

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid |-> (idx <= last_idx))
        else $error("byte step past end of request");

    a_step_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !req_valid |-> (step_reg == STEP_COL_CMD))
        else $error("step counter running without a request");

    a_take_clears_step: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (step_reg == STEP_COL_CMD))
        else $error("step counter not cleared after final byte");

endmodule

@@ rtl/lcd_window_pixel_writer_core.sv @@
// top level: configuration registers, input register and byte sequencer
// depends on lwpw_pkg, lwpw_req_stage, lwpw_byte_gen
//
// channel   direction  payload
// s_axis    in         tdata x_start,y_start,width,height,color; tuser func
// m_axis    out        tdata out_byte; tuser is_data; tlast last
// cfg       in         cfg_index, cfg_data, always ready
//
// one byte per cycle while the output is not stalled: draw pixel sends 13 bytes, set window 11, push colour 2
// the step counter over the held request selects each byte; an unused selector is taken and dropped
// a new request is taken in the cycle its predecessor's final byte enters the output register
// reset loads command bytes 42, 43, 44 and empties both registers
// a stalled output holds its beat; the held request waits behind it

module lcd_window_pixel_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // x_start, y_start, width, height, color
    input  logic [1:0]  s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte
    output logic        m_axis_tuser,  // is_data
    output logic        m_axis_tlast,  // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import lwpw_pkg::*;

    cmd_set_t cmds_reg;
    cmd_set_t cmds_next;
    logic     req_valid;
    req_t     req;
    logic     req_take;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cmds_next = cmds_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COLUMN_CMD: cmds_next.column_cmd = cfg_data;
                CFG_PAGE_CMD:   cmds_next.page_cmd   = cfg_data;
                CFG_MEMWR_CMD:  cmds_next.memwr_cmd  = cfg_data;
                default:        cmds_next            = cmds_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmds_reg.column_cmd <= 8'd42;
            cmds_reg.page_cmd   <= 8'd43;
            cmds_reg.memwr_cmd  <= 8'd44;
        end
        else
        begin
            cmds_reg <= cmds_next;
        end
    end

    lwpw_req_stage u_req_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .req_valid     (req_valid),
        .req           (req),
        .req_take      (req_take)
    );

    lwpw_byte_gen u_byte_gen (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req           (req),
        .req_take      (req_take),
        .cmds          (cmds_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
